>>> sv/pes_pkg.sv
// Package for the piecewise exponential sampler: payload types, sizes, codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pes_pkg;
    localparam int MaxSegments = 64;
    localparam int IdxW = $clog2(MaxSegments);
    localparam int HzW = 40;
    localparam logic [HzW-1:0] HzMax = {HzW{1'b1}};
    localparam logic [31:0] TMax = 32'hFFFF_FFFF;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [5:0]  seg_index;
        logic [31:0] seg_start;
        logic [31:0] seg_rate;
        logic [31:0] from_time;
        logic [31:0] exp_variate;
    } t_in;

    typedef struct packed {
        logic [31:0] sample_time;
        logic [1:0]  status;
    } t_out;

    // Queue entry between front and back: classified item.
    typedef struct packed {
        logic        is_load;
        logic        in_range;
        logic [5:0]  seg_index;
        logic [31:0] seg_start;
        logic [31:0] seg_rate;
        logic [31:0] from_time;
        logic [31:0] exp_variate;
    } t_cmd;
endpackage
`default_nettype wire

>>> sv/pes_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pes_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/pes_front.sv
// Front end: accepts input words, classifies them and pushes a two-entry queue.
// Depends on pes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pes_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire pes_pkg::t_in  i_data,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_pop,
    output pes_pkg::t_cmd      o_cmd
);
    import pes_pkg::*;
    t_cmd r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic r_rd, r_wr;
    logic push;
    t_cmd c;

    always_comb begin
        c.is_load = (i_data.func == FUNC_LOAD);
        c.in_range = ({26'd0, i_data.seg_index} < 32'(MaxSegments));
        c.seg_index = i_data.seg_index;
        c.seg_start = i_data.seg_start;
        c.seg_rate = i_data.seg_rate;
        c.from_time = i_data.from_time;
        c.exp_variate = i_data.exp_variate;
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rd];
    assign n_cnt = r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= ~r_wr;
            if (i_cmd_pop) r_rd <= ~r_rd;
        end
        if (push) r_q[r_wr] <= c;
    end
endmodule
`default_nettype wire

>>> sv/pes_back.sv
// Back end: sequencer over the segment RAMs, searches, multiply and divider.
// Depends on pes_pkg and pes_ram.
`timescale 1ns / 1ps
`default_nettype none
module pes_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [6:0]    i_seg_count,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire pes_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_stall,
    output pes_pkg::t_out      o_data
);
    import pes_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD = 4'd1;   // issue read at r_addr
    localparam logic [3:0] S_WT = 4'd2;   // RAM latency
    localparam logic [3:0] S_SRCH = 4'd3; // evaluate read data for the phase: a scan step, a check or a setup
    localparam logic [3:0] S_MUL = 4'd4;
    localparam logic [3:0] S_ACC = 4'd5;
    localparam logic [3:0] S_DIV = 4'd6;
    localparam logic [3:0] S_FIN = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;
    localparam logic [3:0] S_SUM = 4'd10;

    // phase of the load or sample sequence
    localparam logic [2:0] P_LOADPREV = 3'd0;
    localparam logic [2:0] P_S1LAST = 3'd1;
    localparam logic [2:0] P_S1SCAN = 3'd2;
    localparam logic [2:0] P_I0 = 3'd3;
    localparam logic [2:0] P_S2LAST = 3'd4;
    localparam logic [2:0] P_S2SCAN = 3'd5;
    localparam logic [2:0] P_J = 3'd6;

    logic [3:0] r_st;
    logic [2:0] r_ph;
    t_cmd r_c;
    logic [IdxW-1:0] r_addr, r_n1;
    logic [IdxW:0] r_k;
    logic [31:0] r_s, r_r;
    logic [HzW-1:0] r_h;
    logic [HzW-1:0] r_v;
    logic [31:0] r_dt;
    logic [63:0] r_prod;
    logic r_sat;
    logic [63:0] r_dvd;
    logic [32:0] r_rem;
    logic [32:0] r_quo;
    logic [5:0] r_dcnt;
    t_out r_out;
    logic r_ov;

    logic r_we;
    logic [31:0] rd_s, rd_r;
    logic [HzW-1:0] rd_h;
    logic [HzW-1:0] wh;

    logic [6:0] ncnt;
    assign ncnt = (i_seg_count == 7'd0) ? 7'd1 :
                  ({25'd0, i_seg_count} > 32'(MaxSegments)) ? 7'(MaxSegments) : i_seg_count;

    pes_ram #(.Width(32), .Depth(MaxSegments)) u_start (
        .i_clk, .i_we(r_we), .i_waddr(r_c.seg_index[IdxW-1:0]), .i_wdata(r_c.seg_start),
        .i_raddr(r_addr), .o_rdata(rd_s));
    pes_ram #(.Width(32), .Depth(MaxSegments)) u_rate (
        .i_clk, .i_we(r_we), .i_waddr(r_c.seg_index[IdxW-1:0]), .i_wdata(r_c.seg_rate),
        .i_raddr(r_addr), .o_rdata(rd_r));
    pes_ram #(.Width(HzW), .Depth(MaxSegments)) u_hz (
        .i_clk, .i_we(r_we), .i_waddr(r_c.seg_index[IdxW-1:0]), .i_wdata(wh),
        .i_raddr(r_addr), .o_rdata(rd_h));

    // accrued sum with saturation
    logic [HzW:0] acc_sum;
    assign acc_sum = {1'b0, r_h} + {1'b0, r_prod[63:24]};
    assign wh = (r_ph == P_LOADPREV && r_c.seg_index != 6'd0) ?
                (acc_sum[HzW] ? HzMax : acc_sum[HzW-1:0]) : '0;

    logic [32:0] trial;
    assign trial = {r_rem[31:0], r_dvd[63]} - {1'b0, r_r};
    logic [32:0] tt;
    assign tt = {1'b0, r_s} + r_quo;

    assign o_cmd_pop = (r_st == S_IDLE) && i_cmd_valid;
    assign o_valid = (r_st == S_OUT);
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_we <= 1'b0;
        end else begin
            r_we <= (r_st == S_FIN);
            unique case (r_st)
                S_IDLE: if (i_cmd_valid) begin
                    r_c <= i_cmd;
                    r_sat <= 1'b0;
                    r_n1 <= IdxW'(ncnt - 7'd1);
                    r_h <= '0;
                    if (i_cmd.is_load) begin
                        r_ph <= P_LOADPREV;
                        if (!i_cmd.in_range) begin
                            r_out <= '{sample_time: 32'd0, status: ST_LOAD};
                            r_st <= S_OUT;
                        end else if (i_cmd.seg_index == 6'd0) begin
                            r_st <= S_FIN;
                        end else begin
                            r_addr <= IdxW'(i_cmd.seg_index - 6'd1);
                            r_st <= S_WT;
                        end
                    end else if (i_cmd.from_time == 32'd0) begin
                        r_v <= {8'd0, i_cmd.exp_variate};
                        r_ph <= P_S2LAST;
                        r_addr <= IdxW'(ncnt - 7'd1);
                        r_st <= S_WT;
                    end else begin
                        r_ph <= P_S1LAST;
                        r_addr <= IdxW'(ncnt - 7'd1);
                        r_st <= S_WT;
                    end
                end
                S_RD: r_st <= S_WT;
                S_WT: r_st <= S_SRCH;
                S_SRCH: begin
                    unique case (r_ph)
                        P_LOADPREV, P_I0: begin
                            r_s <= rd_s; r_r <= rd_r; r_h <= rd_h;
                            r_dt <= (r_c.seg_start > rd_s && r_ph == P_LOADPREV) ?
                                    r_c.seg_start - rd_s :
                                    (r_c.from_time > rd_s && r_ph == P_I0) ?
                                    r_c.from_time - rd_s : 32'd0;
                            r_st <= S_MUL;
                        end
                        P_S1LAST: begin
                            if (r_c.from_time >= rd_s) begin
                                r_ph <= P_I0; r_st <= S_SRCH;
                            end else begin
                                r_ph <= P_S1SCAN; r_k <= '0; r_addr <= '0; r_st <= S_RD;
                            end
                        end
                        P_S1SCAN: begin
                            if (rd_s < r_c.from_time && r_k[IdxW-1:0] != r_n1) begin
                                r_k <= r_k + 1'b1;
                                r_addr <= r_k[IdxW-1:0] + 1'b1;
                                r_st <= S_RD;
                            end else begin
                                // first k with start >= from, or k reached n-1
                                r_ph <= P_I0;
                                if (rd_s < r_c.from_time) begin
                                    r_addr <= r_n1;
                                end else begin
                                    r_addr <= (r_k == '0) ? '0 : r_k[IdxW-1:0] - 1'b1;
                                end
                                r_st <= S_RD;
                            end
                        end
                        P_S2LAST: begin
                            if (r_v >= rd_h) begin
                                r_ph <= P_J; r_st <= S_SRCH;
                            end else begin
                                r_ph <= P_S2SCAN; r_k <= '0; r_addr <= '0; r_st <= S_RD;
                            end
                        end
                        P_S2SCAN: begin
                            if (rd_h < r_v && r_k[IdxW-1:0] != r_n1) begin
                                r_k <= r_k + 1'b1;
                                r_addr <= r_k[IdxW-1:0] + 1'b1;
                                r_st <= S_RD;
                            end else begin
                                r_ph <= P_J;
                                if (rd_h < r_v) r_addr <= r_n1;
                                else r_addr <= (r_k == '0) ? '0 : r_k[IdxW-1:0] - 1'b1;
                                r_st <= S_RD;
                            end
                        end
                        default: begin // P_J: set up division
                            r_s <= rd_s; r_r <= rd_r;
                            r_dvd <= {(r_v > rd_h) ? r_v - rd_h : 40'd0, 24'd0};
                            r_rem <= '0; r_quo <= '0; r_ov <= 1'b0;
                            r_dcnt <= 6'd0;
                            if (r_sat || rd_r == 32'd0) begin
                                r_out <= '{sample_time: TMax, status: ST_SAT};
                                r_st <= S_OUT;
                            end else begin
                                r_st <= S_DIV;
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    r_prod <= r_dt * r_r;
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    if (r_ph == P_LOADPREV) begin
                        r_st <= S_FIN;
                    end else begin
                        // target = accrued + variate, saturating
                        logic [HzW:0] vs;
                        vs = (acc_sum[HzW] ? {1'b0, HzMax} : {1'b0, acc_sum[HzW-1:0]})
                             + {9'd0, r_c.exp_variate};
                        r_sat <= r_sat | acc_sum[HzW] | vs[HzW];
                        if (vs[HzW]) begin
                            r_v <= HzMax;
                        end else begin
                            r_v <= vs[HzW-1:0];
                        end
                        r_ph <= P_S2LAST;
                        r_addr <= r_n1;
                        r_st <= S_RD;
                    end
                end
                S_FIN: begin
                    r_out <= '{sample_time: 32'd0, status: ST_LOAD};
                    r_st <= S_OUT;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    if (!trial[32]) begin
                        r_rem <= trial;
                        r_quo <= {r_quo[31:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], r_dvd[63]};
                        r_quo <= {r_quo[31:0], 1'b0};
                    end
                    if (r_quo[32]) r_ov <= 1'b1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 6'd63) r_st <= S_SUM;
                end
                S_SUM: begin
                    if (r_ov || r_quo[32] || tt[32]) begin
                        r_out <= '{sample_time: TMax, status: ST_SAT};
                    end else begin
                        r_out <= '{sample_time: tt[31:0], status: ST_OK};
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (!i_stall) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/piecewise_exponential_sampler_core.sv
// Piecewise exponential sampler, top level: front queue, back sequencer, config.
// Depends on pes_pkg, pes_front, pes_back.
//
// Input channel i_valid/o_stall carries one t_in word: func 0 loads one segment
// (start, rate; cumulative hazard computed from the segment below), func 1 draws
// one sample from from_time using exp_variate. Each word yields one t_out word
// on o_valid/i_stall. A load of segment 0 needs no read; any other load reads the
// segment below and accrues its hazard. A sample runs up to two linear scans over
// the segment RAMs (up to 64 entries each) and, unless saturated or at zero rate,
// a 64-step restoring division, one quotient bit per cycle. The back end works on
// one word at a time and takes the next in the cycle after its result is accepted.
// The front queue holds two words, so input is taken while the back end works or
// its result waits on i_stall, until full. i_cfg_we writes segment_count; the user
// must write it only while the block is idle, which the block does not enforce.
// Synchronous active-low reset empties the queue, idles the sequencer and sets
// segment_count to 1; segment stores are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_exponential_sampler_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire pes_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output pes_pkg::t_out      o_data,
    input  wire logic          i_cfg_we,
    input  wire logic [6:0]    i_cfg_data
);
    import pes_pkg::*;
    logic [6:0] r_seg_count;
    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seg_count <= 7'd1;
        else if (i_cfg_we) r_seg_count <= i_cfg_data;
    end

    pes_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop), .o_cmd(cmd));

    pes_back u_back (
        .i_clk, .i_rst_n, .i_seg_count(r_seg_count),
        .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop), .i_cmd(cmd),
        .o_valid, .i_stall, .o_data);
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Testbench for piecewise_exponential_sampler_core: loads hazard tables, draws samples.
// Depends on pes_pkg and the core; checks every result word against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import pes_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_word;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_data = 7'd1;

    piecewise_exponential_sampler_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_word),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_word),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // predictor state
    logic [31:0] seg_starts [MaxSegments];
    logic [31:0] seg_rates [MaxSegments];
    logic [39:0] seg_hazards [MaxSegments];
    logic [6:0]  seg_count_reg = 7'd1;
    int          loaded = 0;  // one past the highest segment index written
    t_out        pending_q[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic logic [39:0] accrue_hazard(input logic [39:0] hz, input logic [31:0] dt,
                                                  input logic [31:0] rate, inout logic sat);
        logic [63:0] add;
        logic [64:0] sum;
        add = ({32'd0, dt} * {32'd0, rate}) >> 24;
        sum = {25'd0, hz} + {1'b0, add};
        if (sum > {25'd0, HzMax}) begin
            sat = 1'b1;
            return HzMax;
        end
        return sum[39:0];
    endfunction

    function automatic t_out predict_sample(input t_in w);
        t_out r;
        int n, i0, j, k;
        logic sat;
        logic [39:0] h0;
        logic [40:0] v;
        logic [39:0] dv;
        logic [63:0] q;
        logic [32:0] tt;
        sat = 1'b0;
        h0 = '0;
        r.sample_time = TMax;
        r.status = ST_SAT;
        n = seg_count_reg;
        if (n < 1) n = 1;
        if (n > MaxSegments) n = MaxSegments;
        if (w.from_time > 0) begin
            if (w.from_time >= seg_starts[n-1]) i0 = n - 1;
            else begin
                k = 0;
                while (k < n && seg_starts[k] < w.from_time) k++;
                i0 = (k > 0) ? k - 1 : 0;
            end
            h0 = accrue_hazard(seg_hazards[i0],
                (w.from_time > seg_starts[i0]) ? w.from_time - seg_starts[i0] : 32'd0,
                seg_rates[i0], sat);
        end
        v = {1'b0, h0} + {9'd0, w.exp_variate};
        if (v > {1'b0, HzMax}) begin
            v = {1'b0, HzMax};
            sat = 1'b1;
        end
        if (v >= {1'b0, seg_hazards[n-1]}) j = n - 1;
        else begin
            k = 0;
            while (k < n && {1'b0, seg_hazards[k]} < v) k++;
            j = (k > 0) ? k - 1 : 0;
        end
        if (!sat && seg_rates[j] != 0) begin
            dv = (v[39:0] > seg_hazards[j]) ? v[39:0] - seg_hazards[j] : 40'd0;
            q = {dv, 24'd0} / {32'd0, seg_rates[j]};
            if (q <= {32'd0, TMax}) begin
                tt = {1'b0, seg_starts[j]} + {1'b0, q[31:0]};
                if (!tt[32]) begin
                    r.sample_time = tt[31:0];
                    r.status = ST_OK;
                end
            end
        end
        return r;
    endfunction

    function automatic t_out predict_word(input t_in w);
        t_out r;
        logic sat;
        logic [31:0] ps;
        sat = 1'b0;
        if (w.func == FUNC_SAMPLE) return predict_sample(w);
        if (w.seg_index == 0) seg_hazards[0] = '0;
        else begin
            ps = seg_starts[w.seg_index-1];
            seg_hazards[w.seg_index] = accrue_hazard(seg_hazards[w.seg_index-1],
                (w.seg_start > ps) ? w.seg_start - ps : 32'd0, seg_rates[w.seg_index-1], sat);
        end
        seg_starts[w.seg_index] = w.seg_start;
        seg_rates[w.seg_index] = w.seg_rate;
        if (w.seg_index + 1 > loaded) loaded = w.seg_index + 1;
        r.sample_time = '0;
        r.status = ST_LOAD;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // hold stall pseudo-randomly and check each accepted word
    always @(posedge clk) begin
        t_out exp_w;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected word", out_word.sample_time, 32'd0);
            else begin
                exp_w = pending_q.pop_front();
                if (out_word.sample_time !== exp_w.sample_time)
                    report_mismatch("sample_time", out_word.sample_time, exp_w.sample_time);
                if (out_word.status !== exp_w.status)
                    report_mismatch("status", {30'd0, out_word.status},
                                    {30'd0, exp_w.status});
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // valid stays high after acceptance until the next idle cycle or drain
    task automatic send_word(input t_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_q.push_back(predict_word(w));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(input int n);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= n[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        seg_count_reg = n[6:0];
        @(posedge clk);
    endtask

    function automatic t_in make_load(input int idx, input logic [31:0] st,
                                      input logic [31:0] rt);
        t_in w;
        w = '0;
        w.func = FUNC_LOAD;
        w.seg_index = idx[5:0];
        w.seg_start = st;
        w.seg_rate = rt;
        w.from_time = $urandom();
        w.exp_variate = $urandom();
        return w;
    endfunction

    function automatic t_in make_sample(input logic [31:0] ft, input logic [31:0] ev);
        t_in w;
        w = '0;
        w.func = FUNC_SAMPLE;
        w.seg_index = 6'($urandom());
        w.seg_start = $urandom();
        w.seg_rate = $urandom();
        w.from_time = ft;
        w.exp_variate = ev;
        return w;
    endfunction

    function automatic logic [31:0] rand_time;
        case ($urandom_range(3))
            0: return $urandom_range(32'h40000);
            1: return $urandom();
            2: return 32'hFFFF_FFFF - $urandom_range(255);
            default: return $urandom_range(32'h0100_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_rate;
        case ($urandom_range(4))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(32'h0400_0000, 32'h0001_0000);
        endcase
    endfunction

    // load a table of n segments with mostly increasing starts
    task automatic load_table(input int n);
        logic [31:0] st;
        st = $urandom_range(32'h0004_0000);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) st = $urandom();
            send_word(make_load(i, st, rand_rate()));
            st = st + $urandom_range(32'h0008_0000);
        end
    endtask

    task automatic test_directed;
        write_count(1);
        send_word(make_load(0, 32'd0, 32'h0100_0000));
        send_word(make_sample(32'd0, 32'd0));
        send_word(make_sample(32'd0, 32'hFFFF_FFFF));
        send_word(make_sample(32'hFFFF_FFFF, 32'h0001_0000));
        send_word(make_load(0, 32'h0010_0000, 32'd0));
        send_word(make_sample(32'h0001_0000, 32'h0001_0000));   // zero rate
        send_word(make_load(0, 32'h0001_0000, 32'h0100_0000));
        send_word(make_load(1, 32'h0000_8000, 32'hFFFF_FFFF));   // decreasing start
        send_word(make_load(2, 32'hFFFF_FFFF, 32'h0000_0001));   // hazard near full scale
        send_word(make_load(3, 32'hFFFF_FFFF, 32'h0200_0000));
        write_count(4);
        send_word(make_sample(32'h0000_4000, 32'd0));           // before first start
        send_word(make_sample(32'h0000_C000, 32'h0000_0100));
        send_word(make_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_sample(32'h0002_0000, 32'h0000_0001));
        write_count(0);
        send_word(make_sample(32'h0000_4000, 32'h0003_0000));
        send_word(make_load(0, 32'd0, 32'h0000_0001));           // tiny rate: time overflow
        send_word(make_sample(32'd0, 32'hFFFF_FFFF));
        write_count(1);
        send_word(make_sample(32'd0, 32'h0000_0001));
    endtask

    task automatic test_random(input int words);
        int n;
        int sent;
        sent = 0;
        while (sent < words) begin
            n = ($urandom_range(9) == 0) ? MaxSegments : $urandom_range(8, 1);
            drain();
            load_table(n);
            sent += n;
            // an oversized count only once every segment has been written
            if ($urandom_range(3) == 0)
                write_count(($urandom_range(1) && loaded >= MaxSegments) ? 127 : 0);
            else write_count(n);
            for (int s = 0; s < 40; s++) begin
                if ($urandom_range(19) == 0)
                    send_word(make_load($urandom_range(n - 1), rand_time(), rand_rate()));
                else
                    send_word(make_sample(rand_time(), rand_time()));
                sent++;
            end
        end
    endtask

    task automatic test_pause;
        send_idle_pct = 0;
        recv_stall_pct = 30;
        test_random(60);
        // hold the sender until the block has answered everything
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        test_random(60);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(350);
        send_idle_pct = 60; recv_stall_pct = 0;  test_random(350);
        send_idle_pct = 0;  recv_stall_pct = 60; test_random(350);
        send_idle_pct = 20; recv_stall_pct = 20; test_random(300);
        test_pause();
        drain();
        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
